// ----- rtl/sgdw_pkg.sv -----
`default_nettype none

package sgdw_pkg;

	// Glyph geometry and scale limits
	localparam int GLYPH_SIZE        = 8;
	localparam int MAX_SCALE_DEFAULT = 15;
	localparam int SCALE_IN_W        = 4;
	localparam int GLYPH_BITS        = GLYPH_SIZE * GLYPH_SIZE;
	localparam int GIDX_W            = $clog2(GLYPH_SIZE);
	localparam int WORD_W            = 16;
	localparam int COORD_W           = 9;
	localparam int STEP_W            = 4;
	localparam int POS_W             = 3;

	// Panel commands, high byte zero
	localparam logic [WORD_W-1:0] CMD_COLUMN   = 16'h002A;
	localparam logic [WORD_W-1:0] CMD_PAGE     = 16'h002B;
	localparam logic [WORD_W-1:0] CMD_MEMWRITE = 16'h002C;

	// Request kinds
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_PULL = 1'b1;

	// Header sequence steps
	localparam logic [STEP_W-1:0] STEP_PAGE_CMD = 4'd0;
	localparam logic [STEP_W-1:0] STEP_COL_CMD  = 4'd5;
	localparam logic [STEP_W-1:0] STEP_MEMWRITE = 4'd10;
	localparam logic [STEP_W-1:0] STEP_PIXEL    = 4'd11;

	// Position inside one address group
	localparam logic [POS_W-1:0] POS_CMD      = 3'd0;
	localparam logic [POS_W-1:0] POS_START_HI = 3'd1;
	localparam logic [POS_W-1:0] POS_START_LO = 3'd2;
	localparam logic [POS_W-1:0] POS_END_HI   = 3'd3;
	localparam logic [POS_W-1:0] POS_END_LO   = 3'd4;

	typedef struct packed {
		logic                  req_type;
		logic [GLYPH_BITS-1:0] glyph_rows;
		logic [COORD_W-1:0]    start_x;
		logic [COORD_W-1:0]    start_y;
		logic [SCALE_IN_W-1:0] scale;
		logic [4:0]            fg_red;
		logic [5:0]            fg_green;
		logic [4:0]            fg_blue;
		logic [4:0]            bg_red;
		logic [5:0]            bg_green;
		logic [4:0]            bg_blue;
	} req_t;

	typedef struct packed {
		logic              is_data;
		logic [WORD_W-1:0] bus_word;
		logic              last_word;
	} rsp_t;

	// Sequencer result toward the output register
	typedef struct packed {
		logic valid;
		rsp_t word;
	} seq_res_t;

endpackage

`default_nettype wire

// ----- rtl/scaled_glyph_display_writer_unit.sv -----
`default_nettype none

// Scaled glyph writer for an RGB565 panel on a 16-bit parallel bus. A load
// request (req_type 0) latches an 8x8 one-bit glyph, window origin, scale
// (0 reads as 1, values above MAX_SCALE are clipped) and two colors; a load
// while a glyph is still in progress is dropped. Each pull (req_type 1) then
// returns one bus word: page address command and four words, column address
// command and four words, memory write command, then (8*scale)^2 pixels row
// by row, the final pixel flagged with last_word. Pulls while idle and all
// loads return nothing. Every request is handled in the cycle it transfers
// and its word lands in a single output register, so one request per cycle
// is sustained; req_ready drops only while that register is full and the
// downstream side is stalling.
module scaled_glyph_display_writer_unit #(
	parameter int MAX_SCALE = sgdw_pkg::MAX_SCALE_DEFAULT
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	output logic                 req_ready,
	input  wire sgdw_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire                  rsp_ready,
	output sgdw_pkg::rsp_t       rsp
);
	import sgdw_pkg::*;

	logic     rsp_valid_q;
	rsp_t     rsp_q;
	logic     take;
	seq_res_t res;

	// Accept whenever the output register frees up this cycle
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign take      = req_valid && req_ready;

	sgdw_seq #(
		.MAX_SCALE(MAX_SCALE)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (req),
		.res    (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res.valid) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			rsp_q <= res.word;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ready) |-> !res.valid)
		else $error("pending transfer overwritten");

	a_res_from_take: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> take)
		else $error("result without an accepted request");

	a_fill_after_res: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |=> (rsp_valid_q && rsp_q == $past(res.word)))
		else $error("result not captured");

endmodule

`default_nettype wire

// ----- rtl/sgdw_seq.sv -----
`default_nettype none

module sgdw_seq #(
	parameter int MAX_SCALE = sgdw_pkg::MAX_SCALE_DEFAULT
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    take,
	input  wire sgdw_pkg::req_t    item,
	output sgdw_pkg::seq_res_t     res
);
	import sgdw_pkg::*;

	localparam int SCALE_W = $clog2(MAX_SCALE + 1);
	localparam int CMP_W   = (SCALE_W > SCALE_IN_W) ? SCALE_W : SCALE_IN_W;
	localparam int SPAN_W  = $clog2(GLYPH_SIZE * MAX_SCALE);

	// Control state
	logic               busy_q;
	logic [STEP_W-1:0]  step_q;
	logic [GIDX_W-1:0]  row_q;
	logic [GIDX_W-1:0]  col_q;
	logic [SCALE_W-1:0] row_rep_q;
	logic [SCALE_W-1:0] col_rep_q;

	// Latched request
	logic [GLYPH_BITS-1:0] glyph_q;
	logic [COORD_W-1:0]    win_x_q;
	logic [COORD_W-1:0]    win_y_q;
	logic [SCALE_W-1:0]    scale_m1_q;
	logic [SPAN_W-1:0]     span_q;
	logic [WORD_W-1:0]     fg_q;
	logic [WORD_W-1:0]     bg_q;

	logic [CMP_W-1:0]   scale_ext;
	logic [CMP_W-1:0]   scale_clip;
	logic               is_load;
	logic               is_pull;
	logic               in_col;
	logic [COORD_W-1:0] start;
	logic [POS_W-1:0]   pos;
	logic [WORD_W-1:0]  win_end;
	logic               col_wrap;
	logic               gcol_wrap;
	logic               row_wrap;
	logic               grow_wrap;

	assign is_load = take && (item.req_type == REQ_LOAD) && !busy_q;
	assign is_pull = take && (item.req_type == REQ_PULL) && busy_q;

	// Scale clamp to 1..MAX_SCALE
	always_comb begin
		scale_ext = CMP_W'(item.scale);
		priority if (scale_ext == '0) begin
			scale_clip = CMP_W'(1);
		end else if (scale_ext > CMP_W'(MAX_SCALE)) begin
			scale_clip = CMP_W'(MAX_SCALE);
		end else begin
			scale_clip = scale_ext;
		end
	end

	// Header address group selection
	assign in_col  = (step_q >= STEP_COL_CMD);
	assign start   = in_col ? win_x_q : win_y_q;
	assign pos     = POS_W'(in_col ? (step_q - STEP_COL_CMD) : step_q);
	assign win_end = WORD_W'(start) + WORD_W'(span_q);

	// Replication counter wraps
	assign col_wrap  = (col_rep_q == scale_m1_q);
	assign gcol_wrap = (col_q == GIDX_W'(GLYPH_SIZE - 1));
	assign row_wrap  = (row_rep_q == scale_m1_q);
	assign grow_wrap = (row_q == GIDX_W'(GLYPH_SIZE - 1));

	// Output word
	always_comb begin
		res.valid          = is_pull;
		res.word.is_data   = 1'b1;
		res.word.bus_word  = '0;
		res.word.last_word = 1'b0;
		priority if (step_q < STEP_MEMWRITE) begin
			unique case (pos)
				POS_CMD: begin
					res.word.is_data  = 1'b0;
					res.word.bus_word = in_col ? CMD_COLUMN : CMD_PAGE;
				end
				POS_START_HI: res.word.bus_word = WORD_W'(start >> 8);
				POS_START_LO: res.word.bus_word = WORD_W'(start);
				POS_END_HI:   res.word.bus_word = win_end >> 8;
				default:      res.word.bus_word = win_end;
			endcase
		end else if (step_q == STEP_MEMWRITE) begin
			res.word.is_data  = 1'b0;
			res.word.bus_word = CMD_MEMWRITE;
		end else begin
			// bit 7 of each row byte is the leftmost column
			res.word.bus_word  = glyph_q[{row_q, ~col_q}] ? fg_q : bg_q;
			res.word.last_word = col_wrap && gcol_wrap && row_wrap && grow_wrap;
		end
	end

	// Control state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			step_q    <= STEP_PAGE_CMD;
			row_q     <= '0;
			col_q     <= '0;
			row_rep_q <= '0;
			col_rep_q <= '0;
		end else if (is_load) begin
			busy_q    <= 1'b1;
			step_q    <= STEP_PAGE_CMD;
			row_q     <= '0;
			col_q     <= '0;
			row_rep_q <= '0;
			col_rep_q <= '0;
		end else if (is_pull) begin
			if (step_q < STEP_PIXEL) begin
				step_q <= step_q + STEP_W'(1);
			end else if (!col_wrap) begin
				col_rep_q <= col_rep_q + SCALE_W'(1);
			end else begin
				col_rep_q <= '0;
				if (!gcol_wrap) begin
					col_q <= col_q + GIDX_W'(1);
				end else begin
					col_q <= '0;
					if (!row_wrap) begin
						row_rep_q <= row_rep_q + SCALE_W'(1);
					end else begin
						row_rep_q <= '0;
						if (!grow_wrap) begin
							row_q <= row_q + GIDX_W'(1);
						end else begin
							row_q  <= '0;
							step_q <= STEP_PAGE_CMD;
							busy_q <= 1'b0;
						end
					end
				end
			end
		end
	end

	// Request payload, written on load only
	always_ff @(posedge clk) begin
		if (is_load) begin
			glyph_q    <= item.glyph_rows;
			win_x_q    <= item.start_x;
			win_y_q    <= item.start_y;
			scale_m1_q <= SCALE_W'(scale_clip - CMP_W'(1));
			span_q     <= SPAN_W'(GLYPH_SIZE * scale_clip - 1);
			fg_q       <= {item.fg_red, item.fg_green, item.fg_blue};
			bg_q       <= {item.bg_red, item.bg_green, item.bg_blue};
		end
	end

	// Checks
	a_res_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> busy_q)
		else $error("result produced while idle");

	a_last_ends_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.word.last_word) |=> (!busy_q && step_q == STEP_PAGE_CMD))
		else $error("sequencer still busy after final pixel");

	a_header_counters_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q < STEP_PIXEL) |-> (row_q == '0 && col_q == '0 &&
		row_rep_q == '0 && col_rep_q == '0))
		else $error("pixel counters moved during header");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_PIXEL)
		else $error("header step out of range");

	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.word.last_word) |-> res.word.is_data)
		else $error("final word flagged as command");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sgdw_pkg::*;

	// Predicts the bus word sequence and checks every returned word in order
	class bus_word_scoreboard;
		rsp_t                  pending_words[$];
		bit                    busy;
		logic [GLYPH_BITS-1:0] glyph;
		logic [COORD_W-1:0]    win_x;
		logic [COORD_W-1:0]    win_y;
		int unsigned           scale_q;
		logic [WORD_W-1:0]     fg;
		logic [WORD_W-1:0]     bg;
		logic [STEP_W-1:0]     step;
		int unsigned           row, row_rep, col, col_rep;
		int unsigned           errors, words_checked, glyphs_done, loads_dropped, max_scale;

		function new();
			busy    = 1'b0;
			scale_q = 1;
			step    = STEP_PAGE_CMD;
			row     = 0;
			row_rep = 0;
			col     = 0;
			col_rep = 0;
		endfunction

		// Called for every accepted request, in transfer order
		function void take_request(req_t r);
			rsp_t                  w;
			int unsigned           s;
			logic [WORD_W-1:0]     origin, last_pos;
			logic [POS_W-1:0]      pos;
			logic [GLYPH_SIZE-1:0] row_bits;
			if (r.req_type == REQ_LOAD) begin
				if (busy) begin
					loads_dropped++;
					return;
				end
				s = r.scale;
				if (s == 0)
					s = 1;
				if (s > MAX_SCALE_DEFAULT)
					s = MAX_SCALE_DEFAULT;
				if (s > max_scale)
					max_scale = s;
				glyph   = r.glyph_rows;
				win_x   = r.start_x;
				win_y   = r.start_y;
				scale_q = s;
				fg      = {r.fg_red, r.fg_green, r.fg_blue};
				bg      = {r.bg_red, r.bg_green, r.bg_blue};
				step    = STEP_PAGE_CMD;
				row     = 0;
				row_rep = 0;
				col     = 0;
				col_rep = 0;
				busy    = 1'b1;
				return;
			end
			if (!busy)
				return;
			w.is_data   = 1'b1;
			w.last_word = 1'b0;
			if (step < STEP_MEMWRITE) begin
				// address groups: page first, then column
				origin   = (step < STEP_COL_CMD) ? WORD_W'(win_y) : WORD_W'(win_x);
				pos      = (step < STEP_COL_CMD) ? POS_W'(step) : POS_W'(step - STEP_COL_CMD);
				last_pos = origin + WORD_W'(GLYPH_SIZE * scale_q) - 16'd1;
				case (pos)
					POS_CMD: begin
						w.is_data  = 1'b0;
						w.bus_word = (step < STEP_COL_CMD) ? CMD_PAGE : CMD_COLUMN;
					end
					POS_START_HI: w.bus_word = origin >> 8;
					POS_START_LO: w.bus_word = origin;
					POS_END_HI:   w.bus_word = last_pos >> 8;
					default:      w.bus_word = last_pos;
				endcase
				step++;
			end else if (step == STEP_MEMWRITE) begin
				w.is_data  = 1'b0;
				w.bus_word = CMD_MEMWRITE;
				step       = STEP_PIXEL;
			end else begin
				// pixel words, leftmost column is bit 7 of the row byte
				row_bits   = glyph[row*GLYPH_SIZE +: GLYPH_SIZE];
				w.bus_word = row_bits[GLYPH_SIZE-1-col] ? fg : bg;
				if (col_rep + 1 < scale_q) begin
					col_rep++;
				end else begin
					col_rep = 0;
					if (col + 1 < GLYPH_SIZE) begin
						col++;
					end else begin
						col = 0;
						if (row_rep + 1 < scale_q) begin
							row_rep++;
						end else begin
							row_rep = 0;
							if (row + 1 < GLYPH_SIZE) begin
								row++;
							end else begin
								w.last_word = 1'b1;
								busy        = 1'b0;
								step        = STEP_PAGE_CMD;
								row         = 0;
								glyphs_done++;
							end
						end
					end
				end
			end
			pending_words.push_back(w);
		endfunction

		function void check_word(rsp_t got);
			rsp_t want;
			if (pending_words.size() == 0) begin
				$error("bus word %0d with none expected: is_data %0d bus_word 0x%04h last_word %0d",
					words_checked, got.is_data, got.bus_word, got.last_word);
				errors++;
				return;
			end
			want = pending_words.pop_front();
			if (got.is_data !== want.is_data) begin
				$error("word %0d is_data: expected %0d, got %0d", words_checked, want.is_data,
					got.is_data);
				errors++;
			end
			if (got.bus_word !== want.bus_word) begin
				$error("word %0d bus_word: expected 0x%04h, got 0x%04h", words_checked,
					want.bus_word, got.bus_word);
				errors++;
			end
			if (got.last_word !== want.last_word) begin
				$error("word %0d last_word: expected %0d, got %0d", words_checked,
					want.last_word, got.last_word);
				errors++;
			end
			words_checked++;
		endfunction
	endclass

	localparam int STALL_LIMIT = 5000;
	localparam int PHASE_ITEMS = 60;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	bus_word_scoreboard sb = new();
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned items_sent     = 0;
	int unsigned quiet_cycles   = 0;

	scaled_glyph_display_writer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver backpressure
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Both channels observed here: requests noted before words are checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				sb.take_request(req);
			if (rsp_valid && rsp_ready)
				sb.check_word(rsp);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic req_t random_req(logic kind);
		req_t r;
		r.req_type   = kind;
		r.glyph_rows = {$urandom, $urandom};
		r.start_x    = COORD_W'($urandom_range(319));
		r.start_y    = COORD_W'($urandom_range(319));
		r.scale      = SCALE_IN_W'($urandom_range(15));
		r.fg_red     = 5'($urandom_range(31));
		r.fg_green   = 6'($urandom_range(63));
		r.fg_blue    = 5'($urandom_range(31));
		r.bg_red     = 5'($urandom_range(31));
		r.bg_green   = 6'($urandom_range(63));
		r.bg_blue    = 5'($urandom_range(31));
		return r;
	endfunction

	// One request transfer, with a random idle gap ahead of it
	task automatic send_req(input req_t r);
		int unsigned gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		items_sent++;
	endtask

	// Hold off the sender until every predicted word has come back
	task automatic drain_words();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_words.size() != 0);
	endtask

	// Load a glyph and pull its whole word sequence, with dropped loads mixed in
	task automatic run_glyph(input req_t ld, input int unsigned noise_pct, input int pause_at);
		int unsigned s, pulls;
		s     = (ld.scale == 0) ? 1 : ld.scale;
		pulls = 11 + GLYPH_SIZE * GLYPH_SIZE * s * s;
		send_req(ld);
		for (int i = 0; i < pulls; i++) begin
			if (i == pause_at)
				drain_words();
			if ($urandom_range(99) < noise_pct)
				send_req(random_req(REQ_LOAD));
			send_req(random_req(REQ_PULL));
		end
	endtask

	initial begin
		req_t        ld;
		int unsigned pick, phase_base;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: pulls while idle, then corner glyphs
		send_req(random_req(REQ_PULL));
		send_req(random_req(REQ_PULL));

		// scale 0 reads as 1, solid glyph at the far column
		ld            = random_req(REQ_LOAD);
		ld.glyph_rows = '1;
		ld.start_x    = 9'd319;
		ld.start_y    = 9'd0;
		ld.scale      = 4'd0;
		ld.fg_red     = '1;
		ld.fg_green   = '1;
		ld.fg_blue    = '1;
		ld.bg_red     = '0;
		ld.bg_green   = '0;
		ld.bg_blue    = '0;
		run_glyph(ld, 0, 30);

		// blank glyph on the last page, white background
		ld            = random_req(REQ_LOAD);
		ld.glyph_rows = '0;
		ld.start_x    = 9'd0;
		ld.start_y    = 9'd319;
		ld.scale      = 4'd1;
		ld.fg_red     = '0;
		ld.fg_green   = '0;
		ld.fg_blue    = '0;
		ld.bg_red     = '1;
		ld.bg_green   = '1;
		ld.bg_blue    = '1;
		run_glyph(ld, 1, -1);

		// checker pattern around the 8-bit address boundary
		ld            = random_req(REQ_LOAD);
		ld.glyph_rows = 64'hAA55_AA55_AA55_AA55;
		ld.start_x    = 9'd255;
		ld.start_y    = 9'd256;
		ld.scale      = 4'd2;
		run_glyph(ld, 5, 100);
		send_req(random_req(REQ_PULL));

		// Random glyphs under each idling mix
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
				default: begin send_idle_pct = 36; recv_stall_pct = 36; end
			endcase
			phase_base = items_sent;
			while (items_sent - phase_base < PHASE_ITEMS) begin
				ld   = random_req(REQ_LOAD);
				pick = $urandom_range(99);
				ld.scale = (pick < 15) ? 4'd0 : (pick < 85) ? 4'd1 : 4'd2;
				pick = $urandom_range(19);
				if (pick == 0)
					ld.glyph_rows = '0;
				else if (pick == 1)
					ld.glyph_rows = '1;
				run_glyph(ld, $urandom_range(10),
					($urandom_range(4) == 0) ? int'($urandom_range(70)) : -1);
				// stray pulls between glyphs
				repeat ($urandom_range(2)) send_req(random_req(REQ_PULL));
			end
			drain_words();
		end

		repeat (20) @(posedge clk);
		$display("Covered %0d glyphs (scale up to %0d), %0d bus words checked, %0d requests sent",
			sb.glyphs_done, sb.max_scale, sb.words_checked, items_sent);
		$display("Loads dropped while busy: %0d; idling mixes: none, sender, receiver, both",
			sb.loads_dropped);
		if (sb.errors == 0 && sb.pending_words.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/sgdw_pkg.sv
rtl/sgdw_seq.sv
rtl/scaled_glyph_display_writer_unit.sv
tb/sv/tb.sv
